// ===== rtl/sbph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_pkg
// Shared constants and types for the sliding bit pattern histogram.
// ----------------------------------------------------------------------------
package sbph_pkg;

  // Default sizing of the bin store
  localparam int MAX_PATTERN_BITS = 16;
  localparam int COUNT_WIDTH      = 40;

  // Register and field widths
  localparam int LEN_W      = 5;
  localparam int LIMIT_W    = 48;
  localparam int CFG_DATA_W = 48;
  localparam int IDX_W      = 16;
  localparam int OUT_CNT_W  = 40;

  // Register indexes on the configuration port
  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_BIT_LIMIT      = 1'b1;

  // Register reset values
  localparam logic [LEN_W-1:0]   PATTERN_LENGTH_RST = 5'd16;
  localparam logic [LIMIT_W-1:0] BIT_LIMIT_RST      = '1;

  // Input item kinds (carried on tuser)
  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Result queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_LVL_W = 2;
  localparam int OUTQ_PTR_W = 2;

  // One result item, bin_count in the low bits
  typedef struct packed {
    logic [IDX_W-1:0]     bin_echo;
    logic [OUT_CNT_W-1:0] bin_count;
  } out_item_t;

  // Status of the result queue towards the front end
  typedef struct packed {
    logic [OUTQ_LVL_W-1:0] level;
    logic                  full;
  } outq_status_t;

endpackage

// ===== rtl/sbph_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbph_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sbph_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_outq
// Small register queue that holds read results until the sink takes them.
// ----------------------------------------------------------------------------
module sbph_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sbph_pkg::out_item_t    item_i,
  output sbph_pkg::outq_status_t status_o,
  input  logic                   m_axis_tready,
  output logic                   m_axis_tvalid,
  output sbph_pkg::out_item_t    m_axis_tdata   // bin_count [39:0], bin_echo [55:40]
);

  localparam int Depth = sbph_pkg::OUTQ_DEPTH;
  localparam int PtrW  = sbph_pkg::OUTQ_PTR_W;
  localparam int LvlW  = sbph_pkg::OUTQ_LVL_W;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sbph_pkg::out_item_t entry_q [Depth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (level_q != '0);
  assign m_axis_tdata  = entry_q[head_q];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    if (pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);
    end
    if (push_i) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + PtrW'(1);
    end
    unique case ({push_i, pop})
      2'b10:   level_d = level_q + LvlW'(1);
      2'b01:   level_d = level_q - LvlW'(1);
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[tail_q] <= item_i;
    end
  end

  assign status_o.level = level_q;
  assign status_o.full  = (level_q == LvlW'(Depth));

endmodule

// ===== rtl/sliding_bit_pattern_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_bit_pattern_histogram
// Sliding-window bit pattern histogram over a serial bit stream.
// ----------------------------------------------------------------------------
// The block takes one request per clock when not stalled. A feed request
// shifts its bit into the window, and the bin the window names is read from
// the bin RAM at once and incremented and written back in the next cycle; a
// one-entry forwarding register covers requests that hit the same bin in
// consecutive cycles, so feeds add no stalls of their own and run at one bit
// per clock while the slave side is ready. A read request fetches the bin in
// the same way; its result is registered in the second stage and then written
// into a three-entry result queue for the master side. Besides clearing, the
// slave side stalls only while that queue and the request in flight fill it.
// After reset the bin RAM is cleared one entry a cycle, and no request is
// accepted until that is done; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module sliding_bit_pattern_histogram #(
  parameter int MaxPatternBits = sbph_pkg::MAX_PATTERN_BITS,
  parameter int CountWidth     = sbph_pkg::COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [sbph_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // bit_in [0], bin_index [16:1]
  input  logic                            s_axis_tuser,  // func [0]
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [55:0]                     m_axis_tdata   // bin_count [39:0], bin_echo [55:40]
);

  localparam int NumBins = 1 << MaxPatternBits;
  localparam int LenW    = sbph_pkg::LEN_W;
  localparam int LimitW  = sbph_pkg::LIMIT_W;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPatternBits);
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Configuration registers
  logic [LenW-1:0]   pattern_length_q;
  logic [LimitW-1:0] bit_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= sbph_pkg::PATTERN_LENGTH_RST;
      bit_limit_q      <= sbph_pkg::BIT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbph_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[LenW-1:0];
        sbph_pkg::REG_BIT_LIMIT:      bit_limit_q      <= cfg_data_i[LimitW-1:0];
        default:                      pattern_length_q <= pattern_length_q;
      endcase
    end
  end

  // Clearing pass over the bin RAM
  logic [MaxPatternBits:0] clr_cnt_q;
  logic                    clr_done;

  assign clr_done = clr_cnt_q[MaxPatternBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (!clr_done) begin
      clr_cnt_q <= clr_cnt_q + (MaxPatternBits + 1)'(1);
    end
  end

  // Request decode
  logic                      in_bit;
  logic [sbph_pkg::IDX_W-1:0] in_idx;
  logic                      s_accept;
  logic                      is_read;
  logic                      feed_ok;

  assign in_bit   = s_axis_tdata[0];
  assign in_idx   = s_axis_tdata[16:1];
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign is_read  = (s_axis_tuser == sbph_pkg::FUNC_READ);

  // Window and bit counter
  logic [MaxPatternBits-1:0] window_q, window_d;
  logic [LimitW-1:0]         bits_seen_q;
  logic [LenW-1:0]           len_eff;
  logic [MaxPatternBits:0]   len_one;
  logic [MaxPatternBits-1:0] win_mask;

  assign len_eff  = (pattern_length_q > MaxLen) ? MaxLen : pattern_length_q;
  assign len_one  = (MaxPatternBits + 1)'(1) << len_eff;
  assign win_mask = MaxPatternBits'(len_one - (MaxPatternBits + 1)'(1));
  assign feed_ok  = (bits_seen_q < bit_limit_q);
  assign window_d = ((window_q << 1) | MaxPatternBits'(in_bit)) & win_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      bits_seen_q <= '0;
    end else if (s_accept && !is_read && feed_ok) begin
      window_q    <= window_d;
      bits_seen_q <= bits_seen_q + LimitW'(1);
    end
  end

  // Second stage: RAM data valid, modify and write back or emit result
  logic                      s1_valid_q;
  logic                      s1_read_q;
  logic [MaxPatternBits-1:0] s1_addr_q;
  logic [MaxPatternBits-1:0] rd_addr;
  logic [MaxPatternBits-1:0] rd_idx;
  logic                      s1_take;

  assign rd_idx  = MaxPatternBits'(in_idx);
  assign rd_addr = is_read ? rd_idx : window_d;
  // drop feeds beyond the limit: they touch nothing
  assign s1_take = s_accept && (is_read || feed_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_read_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_take;
      s1_read_q  <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= rd_addr;
  end

  // Bin RAM
  logic                      ram_we;
  logic [MaxPatternBits-1:0] ram_waddr;
  logic [CountWidth-1:0]     ram_wdata;
  logic [CountWidth-1:0]     ram_rdata;
  logic [CountWidth-1:0]     cur_count;
  logic [CountWidth-1:0]     inc_count;
  logic                      upd_we;

  // Forwarding of the write from the previous cycle
  logic                      fwd_valid_q;
  logic [MaxPatternBits-1:0] fwd_addr_q;
  logic [CountWidth-1:0]     fwd_data_q;

  assign cur_count = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign inc_count = (cur_count == CountMax) ? cur_count : cur_count + CountWidth'(1);
  assign upd_we    = s1_valid_q && !s1_read_q;

  always_comb begin
    if (!clr_done) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q[MaxPatternBits-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_addr_q;
      ram_wdata = inc_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= upd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= inc_count;
  end

  sbph_ram #(
    .Width (CountWidth),
    .Depth (NumBins)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Result queue
  sbph_pkg::out_item_t    res_item;
  sbph_pkg::out_item_t    q_tdata;
  sbph_pkg::outq_status_t q_status;
  logic                   res_push;
  logic [sbph_pkg::OUTQ_LVL_W:0] q_need;

  assign res_push           = s1_valid_q && s1_read_q;
  assign res_item.bin_count = sbph_pkg::OUT_CNT_W'(cur_count);
  assign res_item.bin_echo  = sbph_pkg::IDX_W'(s1_addr_q);

  // hold requests while the queued results and the one in flight fill the queue
  assign q_need        = {1'b0, q_status.level} + (sbph_pkg::OUTQ_LVL_W + 1)'(res_push);
  assign s_axis_tready = clr_done &&
                         (q_need < (sbph_pkg::OUTQ_LVL_W + 1)'(sbph_pkg::OUTQ_DEPTH));

  sbph_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res_push),
    .item_i        (res_item),
    .status_o      (q_status),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (q_tdata)
  );

  assign m_axis_tdata = q_tdata;

  // Assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && q_status.full && !m_axis_tready))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done |-> !s1_valid_q && !m_axis_tvalid)
    else $error("bin activity during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !is_read && feed_ok) |=> bits_seen_q == $past(bits_seen_q) + LimitW'(1))
    else $error("bit counter did not advance on a counted bit");

endmodule
